[hw/rtl/c2dfe_pkg.sv]
// shared types and constants of the fixed-point convolution engine
// no dependencies; imported by the core
package c2dfe_pkg;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 7;
  localparam int unsigned CH_W = 5;   // up to 16 input channels
  localparam int unsigned SZ_W = 9;   // up to 256 rows or columns
  localparam int unsigned OCN_W = 9;  // up to 256 output channels
  localparam int unsigned K_W = 5;    // up to 16 taps
  localparam int unsigned IDX_W = 26; // signed flat index arithmetic
  localparam int unsigned POS_W = 14; // signed row and column positions

  typedef enum logic [1:0] {
    CMD_LOAD_PIXEL  = 2'd0,
    CMD_LOAD_WEIGHT = 2'd1,
    CMD_LOAD_BIAS   = 2'd2,
    CMD_COMPUTE     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_IN_CH    = 3'd0,
    REG_OUT_CH   = 3'd1,
    REG_IN_H     = 3'd2,
    REG_IN_W     = 3'd3,
    REG_KERNEL   = 3'd4,
    REG_STRIDE   = 3'd5,
    REG_PADDING  = 3'd6,
    REG_BIAS_EN  = 3'd7
  } reg_idx_e;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL1   = 7'b0000010,
    ST_MUL2   = 7'b0000100,
    ST_MUL3   = 7'b0001000,
    ST_RUN    = 7'b0010000,
    ST_DRAIN  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

endpackage

[hw/rtl/c2dfe_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module c2dfe_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/conv2d_fixed_point_engine_core.sv]
// direct 2d convolution engine, one image in channel, row, column order
// depends on c2dfe_pkg and c2dfe_ram
//
// Load beats (pixel, weight, bias) write one Q8.8 value; an index beyond
// the store is dropped. A compute beat returns one Q16.16 result beat from
// the single multiply-accumulate that walks every kernel tap in turn, one
// tap per cycle including padded taps, fed by one read port on each of the
// pixel and weight rams. A position outside the output returns status 1.
// The block takes no new beat while a compute runs; loads are taken while
// a result beat waits.
// Configuration writes are always ready and must arrive while idle.
module conv2d_fixed_point_engine_core #(
  parameter int unsigned MAX_IN_CHANNELS  = 4,
  parameter int unsigned MAX_IN_SIZE      = 64,
  parameter int unsigned MAX_OUT_CHANNELS = 64,
  parameter int unsigned MAX_KERNEL       = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [c2dfe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [c2dfe_pkg::CFG_DAT_W-1:0] cfg_data_i,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [15:0]                   buffer_index_i,
  input  logic signed [15:0]            load_value_i,
  input  logic [5:0]                    out_channel_i,
  input  logic [6:0]                    out_row_i,
  input  logic [6:0]                    out_col_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            sum_value_o,
  output logic                          saturated_o,
  output logic                          status_o
);
  import c2dfe_pkg::*;

  localparam int unsigned PIX_DEPTH  = MAX_IN_CHANNELS * MAX_IN_SIZE * MAX_IN_SIZE;
  localparam int unsigned WGT_DEPTH  = MAX_OUT_CHANNELS * MAX_IN_CHANNELS *
                                       MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned BIAS_DEPTH = MAX_OUT_CHANNELS;
  localparam int unsigned PAW = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
  localparam int unsigned WAW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int unsigned BAW = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
  // enough headroom for every product of the largest kernel plus bias
  localparam int unsigned ACC_W = 34 +
                                  $clog2(MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL);

  // configuration registers, stored at their own widths
  logic [2:0] in_ch_q;
  logic [6:0] out_ch_q, in_h_q, in_w_q;
  logic [4:0] kernel_q, stride_q;
  logic [2:0] pad_q;
  logic       bias_en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q   <= 3'd3;
      out_ch_q  <= 7'd64;
      in_h_q    <= 7'd64;
      in_w_q    <= 7'd64;
      kernel_q  <= 5'd16;
      stride_q  <= 5'd16;
      pad_q     <= 3'd0;
      bias_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_IN_CH:   in_ch_q   <= cfg_data_i[2:0];
        REG_OUT_CH:  out_ch_q  <= cfg_data_i;
        REG_IN_H:    in_h_q    <= cfg_data_i;
        REG_IN_W:    in_w_q    <= cfg_data_i;
        REG_KERNEL:  kernel_q  <= cfg_data_i[4:0];
        REG_STRIDE:  stride_q  <= cfg_data_i[4:0];
        REG_PADDING: pad_q     <= cfg_data_i[2:0];
        REG_BIAS_EN: bias_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective sizes after clamping to the build limits; a zero stride counts as one
  logic [CH_W-1:0]  ic_eff;
  logic [OCN_W-1:0] noc_eff;
  logic [SZ_W-1:0]  h_eff, w_eff;
  logic [K_W-1:0]   k_eff, s_eff;

  always_comb begin
    ic_eff  = (CH_W'(in_ch_q) > CH_W'(MAX_IN_CHANNELS)) ? CH_W'(MAX_IN_CHANNELS)
                                                         : CH_W'(in_ch_q);
    noc_eff = (OCN_W'(out_ch_q) > OCN_W'(MAX_OUT_CHANNELS)) ? OCN_W'(MAX_OUT_CHANNELS)
                                                             : OCN_W'(out_ch_q);
    h_eff   = (SZ_W'(in_h_q) > SZ_W'(MAX_IN_SIZE)) ? SZ_W'(MAX_IN_SIZE) : SZ_W'(in_h_q);
    w_eff   = (SZ_W'(in_w_q) > SZ_W'(MAX_IN_SIZE)) ? SZ_W'(MAX_IN_SIZE) : SZ_W'(in_w_q);
    k_eff   = (kernel_q > K_W'(MAX_KERNEL)) ? K_W'(MAX_KERNEL) : kernel_q;
    s_eff   = (stride_q == 5'd0) ? 5'd1 : stride_q;
  end

  state_e state_q, state_d;

  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // latched request
  logic [5:0] oc_q;
  logic [6:0] oy_q, ox_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      oc_q <= out_channel_i;
      oy_q <= out_row_i;
      ox_q <= out_col_i;
    end
  end

  // stores
  logic           pix_we, wgt_we, bias_we;
  logic [PAW-1:0] pix_raddr;
  logic [WAW-1:0] wgt_raddr;
  logic [15:0]    pix_rdata, wgt_rdata, bias_rdata;

  assign pix_we  = in_acc && (cmd_e'(command_i) == CMD_LOAD_PIXEL) &&
                   (32'(buffer_index_i) < PIX_DEPTH);
  assign wgt_we  = in_acc && (cmd_e'(command_i) == CMD_LOAD_WEIGHT) &&
                   (32'(buffer_index_i) < WGT_DEPTH);
  assign bias_we = in_acc && (cmd_e'(command_i) == CMD_LOAD_BIAS) &&
                   (32'(buffer_index_i) < BIAS_DEPTH);

  c2dfe_ram #(.WIDTH(16), .DEPTH(PIX_DEPTH), .AW(PAW)) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (PAW'(buffer_index_i)),
    .wdata_i (load_value_i),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  c2dfe_ram #(.WIDTH(16), .DEPTH(WGT_DEPTH), .AW(WAW)) u_wgt_ram (
    .clk_i   (clk_i),
    .we_i    (wgt_we),
    .waddr_i (WAW'(buffer_index_i)),
    .wdata_i (load_value_i),
    .raddr_i (wgt_raddr),
    .rdata_o (wgt_rdata)
  );

  c2dfe_ram #(.WIDTH(16), .DEPTH(BIAS_DEPTH), .AW(BAW)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (bias_we),
    .waddr_i (BAW'(buffer_index_i)),
    .wdata_i (load_value_i),
    .raddr_i (BAW'(oc_q)),
    .rdata_o (bias_rdata)
  );

  // setup products, each formed by one multiply in ST_MUL1 or ST_MUL2
  logic [11:0]              oys_q, oxs_q;
  logic [2*K_W-1:0]         kk_q;
  logic [2*SZ_W-1:0]        hw_q;
  logic [CH_W+2*K_W-1:0]    ickk_q;
  logic signed [POS_W-1:0]  rb_q, xb_q;
  logic                     oob_q;

  // tap walk
  logic [CH_W-1:0]          c_q;
  logic [K_W-1:0]           kh_q, kw_q;
  logic signed [POS_W-1:0]  r_q, x_q;
  logic signed [IDX_W-1:0]  row0_q, row_q, chan_q, widx_q;
  logic [1:0]               drain_q;

  // mac pipeline
  logic                     p1_v_q;
  logic signed [31:0]       prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic [12:0] span;
  logic        oob;
  logic        tap_ok;
  logic        last_kw, last_kh, last_c;
  logic signed [IDX_W-1:0] pix_idx;

  always_comb begin
    span    = 13'(h_eff) + 13'({pad_q, 1'b0});
    // position lies inside the output when oy*s + k fits within the padded span
    oob     = (OCN_W'(oc_q) >= noc_eff) ||
              ((13'(oys_q) + 13'(k_eff)) > span) ||
              ((13'(oxs_q) + 13'(k_eff)) > (13'(w_eff) + 13'({pad_q, 1'b0})));
    tap_ok  = (r_q >= 0) && (r_q < $signed(POS_W'(h_eff))) &&
              (x_q >= 0) && (x_q < $signed(POS_W'(w_eff)));
    pix_idx = chan_q + row_q + IDX_W'(x_q);
    pix_raddr = PAW'(pix_idx);
    wgt_raddr = WAW'(widx_q);
    last_kw = (kw_q == k_eff - 5'd1);
    last_kh = (kh_q == k_eff - 5'd1);
    last_c  = (c_q == ic_eff - CH_W'(1));
  end

  // result register
  logic out_free;
  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc && (cmd_e'(command_i) == CMD_COMPUTE)) state_d = ST_MUL1;
      ST_MUL1:   state_d = ST_MUL2;
      ST_MUL2:   state_d = oob ? ST_FINISH : ST_MUL3;
      ST_MUL3:   state_d = ((ic_eff == '0) || (k_eff == '0)) ? ST_DRAIN : ST_RUN;
      ST_RUN:    if (last_kw && last_kh && last_c) state_d = ST_DRAIN;
      ST_DRAIN:  if (drain_q == 2'd1) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      drain_q <= 2'd0;
      p1_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      drain_q <= (state_q == ST_DRAIN) ? drain_q + 2'd1 : 2'd0;
      p1_v_q  <= (state_q == ST_RUN) && tap_ok;
    end
  end

  // setup datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_MUL1: begin
        oys_q <= 12'(oy_q) * 12'(s_eff);
        oxs_q <= 12'(ox_q) * 12'(s_eff);
        kk_q  <= k_eff * k_eff;
        hw_q  <= h_eff * w_eff;
      end
      ST_MUL2: begin
        oob_q  <= oob;
        ickk_q <= ic_eff * kk_q;
        rb_q   <= $signed(POS_W'(oys_q)) - $signed(POS_W'(pad_q));
        xb_q   <= $signed(POS_W'(oxs_q)) - $signed(POS_W'(pad_q));
      end
      default: ;
    endcase
  end

  // tap walk: incremental indices, weight index advances on every tap
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL3) begin
      c_q    <= '0;
      kh_q   <= '0;
      kw_q   <= '0;
      r_q    <= rb_q;
      x_q    <= xb_q;
      chan_q <= '0;
      row0_q <= IDX_W'(rb_q) * $signed(IDX_W'(w_eff));
      row_q  <= IDX_W'(rb_q) * $signed(IDX_W'(w_eff));
      widx_q <= IDX_W'(oc_q) * IDX_W'(ickk_q);
    end else if (state_q == ST_RUN) begin
      widx_q <= widx_q + IDX_W'(1);
      if (!last_kw) begin
        kw_q <= kw_q + 5'd1;
        x_q  <= x_q + POS_W'(1);
      end else begin
        kw_q <= '0;
        x_q  <= xb_q;
        if (!last_kh) begin
          kh_q  <= kh_q + 5'd1;
          r_q   <= r_q + POS_W'(1);
          row_q <= row_q + IDX_W'(w_eff);
        end else begin
          kh_q   <= '0;
          r_q    <= rb_q;
          row_q  <= row0_q;
          c_q    <= c_q + CH_W'(1);
          chan_q <= chan_q + IDX_W'(hw_q);
        end
      end
    end
  end

  // multiply-accumulate; bias seeds the accumulator as Q16.16
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else begin
      prod_q <= p1_v_q ? $signed(pix_rdata) * $signed(wgt_rdata) : 32'sd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL3) begin
      acc_q <= bias_en_q ? ACC_W'({{(ACC_W-24){bias_rdata[15]}}, bias_rdata, 8'd0})
                         : '0;
    end else begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // saturation and result register
  logic sat_hi, sat_lo;
  assign sat_hi = acc_q > ACC_W'(32'sh7fffffff);
  assign sat_lo = acc_q < $signed({{(ACC_W-32){1'b1}}, 32'h80000000});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if ((state_q == ST_FINISH) && out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FINISH) && out_free) begin
      status_o <= oob_q;
      if (oob_q) begin
        sum_value_o <= '0;
        saturated_o <= 1'b0;
      end else begin
        priority if (sat_hi) begin
          sum_value_o <= 32'sh7fffffff;
          saturated_o <= 1'b1;
        end else if (sat_lo) begin
          sum_value_o <= 32'sh80000000;
          saturated_o <= 1'b1;
        end else begin
          sum_value_o <= acc_q[31:0];
          saturated_o <= 1'b0;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_compute_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_e'(command_i) == CMD_COMPUTE)) |=> in_stall_o)
    else $error("compute beat did not start the sequencer");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> ((sum_value_o == 32'sd0) && !saturated_o))
    else $error("out-of-range result carries data");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      ((sum_value_o == 32'sh7fffffff) || (sum_value_o == 32'sh80000000)))
    else $error("saturated result is not a limit");
`endif

endmodule
